FILE: sv/sfr_pkg.sv
// Shared types and constants for the stuffed frame receiver.
`default_nettype none
package sfr_pkg;

    localparam int MAX_BODY_BYTES = 1024;
    localparam int BODY_CNT_W     = $clog2(MAX_BODY_BYTES + 1);
    localparam int BYTE_W         = 8;
    localparam int LEN_W          = 11;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [2:0] {
        PH_HUNT     = 3'd0,
        PH_FLAG     = 3'd1,
        PH_ADDR     = 3'd2,
        PH_CTRL_NEW = 3'd3,
        PH_CTRL_DUP = 3'd4,
        PH_BODY     = 3'd5,
        PH_DUP_BODY = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_DUP   = 2'd1,
        ST_CHECK = 2'd2,
        ST_OVER  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLAG     = 3'd0,
        CFG_ESCAPE   = 3'd1,
        CFG_ADDRESS  = 3'd2,
        CFG_CTRL_ZER = 3'd3,
        CFG_CTRL_ONE = 3'd4
    } cfg_idx_t;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] control_seq_zero;
        logic [BYTE_W-1:0] control_seq_one;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload;
        status_t           status;
        logic [LEN_W-1:0]  length;
    } result_t;

endpackage
`default_nettype wire

FILE: sv/sfr_cfg_regs.sv
// Configuration register file of the stuffed frame receiver.
`default_nettype none
module sfr_cfg_regs
    import sfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_FLAG:     cfg_next.flag_byte        = cfg_data;
                CFG_ESCAPE:   cfg_next.escape_byte      = cfg_data;
                CFG_ADDRESS:  cfg_next.address_byte     = cfg_data;
                CFG_CTRL_ZER: cfg_next.control_seq_zero = cfg_data;
                CFG_CTRL_ONE: cfg_next.control_seq_one  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte        <= 8'd126;
            cfg_reg.escape_byte      <= 8'd125;
            cfg_reg.address_byte     <= 8'd3;
            cfg_reg.control_seq_zero <= 8'd0;
            cfg_reg.control_seq_one  <= 8'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: sv/sfr_in_stage.sv
// Input register stage: holds one line byte until the core consumes it.
`default_nettype none
module sfr_in_stage
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] line_byte,
    input  wire logic              advance,
    output logic                   fire,
    output logic [BYTE_W-1:0]      byte_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign fire     = valid_reg && advance;
    assign in_ready = !valid_reg || advance;
    assign byte_out = byte_reg;

    always_comb
    begin
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= line_byte;
    end

endmodule
`default_nettype wire

FILE: sv/sfr_core.sv
// Deframing state machine: header check, destuffing, check byte and status.
`default_nettype none
module sfr_core
    import sfr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              fire,
    input  wire logic [BYTE_W-1:0] line_b,
    output logic                   res_valid,
    output result_t                res
);

    phase_t                phase_reg, phase_next;
    logic                  esc_reg, esc_next;
    logic                  seq_reg, seq_next;
    logic [BYTE_W-1:0]     held_reg, held_next;
    logic                  held_valid_reg, held_valid_next;
    logic [BYTE_W-1:0]     xor_reg, xor_next;
    logic [BODY_CNT_W-1:0] count_reg, count_next;

    logic [BYTE_W-1:0]     c_new;
    logic [BYTE_W-1:0]     c_old;
    logic                  is_flag;
    logic                  is_esc;
    logic [BODY_CNT_W-1:0] count_m1;

    assign c_new    = seq_reg ? cfg.control_seq_one  : cfg.control_seq_zero;
    assign c_old    = seq_reg ? cfg.control_seq_zero : cfg.control_seq_one;
    assign is_flag  = (line_b == cfg.flag_byte);
    assign is_esc   = (line_b == cfg.escape_byte);
    assign count_m1 = count_reg - 1'b1;

    always_comb
    begin
        phase_next      = phase_reg;
        esc_next        = esc_reg;
        seq_next        = seq_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        xor_next        = xor_reg;
        count_next      = count_reg;
        res_valid       = 1'b0;
        res.kind        = KIND_STATUS;
        res.payload     = '0;
        res.status      = ST_GOOD;
        res.length      = '0;

        if (fire)
        begin
            case (phase_reg)
                PH_FLAG:
                begin
                    if (is_flag)
                        phase_next = PH_FLAG;
                    else if (line_b == cfg.address_byte)
                        phase_next = PH_ADDR;
                    else
                        phase_next = PH_HUNT;
                end
                PH_ADDR:
                begin
                    if (is_flag)
                        phase_next = PH_FLAG;
                    else if (line_b == c_new)
                        phase_next = PH_CTRL_NEW;
                    else if (line_b == c_old)
                        phase_next = PH_CTRL_DUP;
                    else
                        phase_next = PH_HUNT;
                end
                PH_CTRL_NEW, PH_CTRL_DUP:
                begin
                    if (is_flag)
                        phase_next = PH_FLAG;
                    else if (line_b == (cfg.address_byte ^
                             ((phase_reg == PH_CTRL_NEW) ? c_new : c_old)))
                    begin
                        phase_next      = (phase_reg == PH_CTRL_NEW) ? PH_BODY : PH_DUP_BODY;
                        esc_next        = 1'b0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        xor_next        = '0;
                        count_next      = '0;
                    end
                    else
                        phase_next = PH_HUNT;
                end
                PH_DUP_BODY:
                begin
                    if (!esc_reg && is_flag)
                    begin
                        phase_next      = PH_HUNT;
                        esc_next        = 1'b0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        xor_next        = '0;
                        count_next      = '0;
                        res_valid       = 1'b1;
                        res.status      = ST_DUP;
                    end
                    else
                        esc_next = !esc_reg && is_esc;
                end
                PH_BODY:
                begin
                    if (!esc_reg && is_flag)
                    begin
                        res_valid = 1'b1;
                        if (count_reg == '0)
                            res.status = ST_CHECK;
                        else
                        begin
                            res.length = LEN_W'(count_m1);
                            if (xor_reg == '0)
                            begin
                                res.status = ST_GOOD;
                                seq_next   = !seq_reg;
                            end
                            else
                                res.status = ST_CHECK;
                        end
                        phase_next      = PH_HUNT;
                        esc_next        = 1'b0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        xor_next        = '0;
                        count_next      = '0;
                    end
                    else if (!esc_reg && is_esc)
                        esc_next = 1'b1;
                    else if (count_reg >= BODY_CNT_W'(MAX_BODY_BYTES))
                    begin
                        // body full: count has reached MAX_BODY_BYTES here
                        res_valid       = 1'b1;
                        res.status      = ST_OVER;
                        res.length      = LEN_W'(count_m1);
                        phase_next      = PH_HUNT;
                        esc_next        = 1'b0;
                        held_next       = '0;
                        held_valid_next = 1'b0;
                        xor_next        = '0;
                        count_next      = '0;
                    end
                    else
                    begin
                        // one byte delay keeps the check byte from leaving
                        esc_next = 1'b0;
                        if (held_valid_reg)
                        begin
                            res_valid   = 1'b1;
                            res.kind    = KIND_PAYLOAD;
                            res.payload = held_reg;
                        end
                        held_next       = line_b;
                        held_valid_next = 1'b1;
                        xor_next        = xor_reg ^ line_b;
                        count_next      = count_reg + 1'b1;
                    end
                end
                default:
                    phase_next = is_flag ? PH_FLAG : PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            esc_reg        <= 1'b0;
            seq_reg        <= 1'b0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            xor_reg        <= '0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            esc_reg        <= esc_next;
            seq_reg        <= seq_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            xor_reg        <= xor_next;
            count_reg      <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_res_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fire)
        else $error("result produced without a consumed byte");

    a_status_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_STATUS)
            |=> (phase_reg == PH_HUNT && count_reg == '0 && !held_valid_reg))
        else $error("frame state not cleared after status");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= BODY_CNT_W'(MAX_BODY_BYTES))
        else $error("body count beyond limit");

    a_payload_from_body: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.kind == KIND_PAYLOAD) |-> (phase_reg == PH_BODY && held_valid_reg))
        else $error("payload byte outside a new-frame body");
`endif

endmodule
`default_nettype wire

FILE: sv/sfr_out_stage.sv
// Output register: holds one result until the consumer takes it.
`default_nettype none
module sfr_out_stage
    import sfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    fire,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         advance,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        if (advance)
            valid_next = fire && res_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && fire && res_valid)
            res_reg <= res;
    end

endmodule
`default_nettype wire

FILE: sv/stuffed_frame_receiver_top.sv
// Top level of the stuffed frame receiver (byte-stuffed framed link deframer).
`default_nettype none
// Takes one received line byte per transaction and accepts a new one every clock
// cycle while results drain. The byte waits in the input register; once the
// output register can take a result, the state update loads any result into it
// and out_valid rises. A result held with out_ready low stalls the input
// register and drops in_ready. The block hunts for the flag byte, checks
// address, control byte (expected or previous sequence bit) and header check,
// then destuffs the body. Payload bytes leave one byte late so the trailing XOR
// check byte is never emitted. A closing flag or a body overflow yields one
// status transaction: good (toggles the expected sequence bit), duplicate, check
// error (also for an empty body) or overflow. Payload bytes before any status
// other than good must be discarded by the user. The user must write registers
// through cfg_we/cfg_index/cfg_data only while the block is idle (not enforced);
// indexes 0..4 are flag, escape, address, control for seq 0, control for seq 1.
module stuffed_frame_receiver_top
    import sfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    line_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      item_kind,
    output logic [BYTE_W-1:0]         payload_byte,
    output logic [1:0]                frame_status,
    output logic [LEN_W-1:0]          payload_length
);

    cfg_t              cfg;
    logic              advance;
    logic              fire;
    logic [BYTE_W-1:0] cur_byte;
    logic              res_valid;
    result_t           res;
    result_t           out_res;

    // configuration registers
    sfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register; drains whenever the output register can take a result
    sfr_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .line_byte (line_byte),
        .advance   (advance),
        .fire      (fire),
        .byte_out  (cur_byte)
    );

    // one state update per consumed byte
    sfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .line_b    (cur_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register toward the consumer
    sfr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .advance   (advance),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign item_kind      = out_res.kind;
    assign payload_byte   = out_res.payload;
    assign frame_status   = out_res.status;
    assign payload_length = out_res.length;

endmodule
`default_nettype wire
